// File: hdl/prmp_pkg.sv
// package for the performance reply max parser: item types and constants
package prmp_pkg;

    localparam int unsigned POS_W     = 13;
    localparam int unsigned END_W     = 33;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned CNT_W     = 9;
    localparam int unsigned OFF_W     = 4;

    localparam int unsigned DESC_CAP_DEFAULT = 256;

    localparam logic [POS_W-1:0] HDR_BYTES  = POS_W'(8);
    localparam logic [POS_W-1:0] LEN_BYTES  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_MAX    = POS_W'(8191);
    localparam logic [POS_W-1:0] LEN_LAST   = LEN_BYTES - POS_W'(1);
    localparam logic [POS_W-1:0] HDR_LAST   = HDR_BYTES - POS_W'(1);
    localparam logic [OFF_W-1:0] OFF_START  = OFF_W'(7);
    localparam logic [OFF_W-1:0] OFF_END    = OFF_W'(15);
    localparam logic [END_W-1:0] END_MIN    = END_W'(8);
    localparam logic [END_W-1:0] LEN_ADD    = END_W'(4);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic              header_ok;
        logic [WORD_W-1:0] peak_perf;
        logic [CNT_W-1:0]  descriptor_count;
    } t_out_item;

endpackage

// File: hdl/prmp_in_reg.sv
// input register: holds one request byte until the parse engine takes it
module prmp_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  prmp_pkg::t_in_item i_item,
    input  logic              i_advance,
    output logic              o_valid,
    output prmp_pkg::t_in_item o_item
);
    import prmp_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     accept;

    assign o_stall = r_valid && !i_advance;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: hdl/prmp_engine.sv
// parse engine: header length, descriptor tracking, running max and count
module prmp_engine #(
    parameter int unsigned DESC_CAP = prmp_pkg::DESC_CAP_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  prmp_pkg::t_in_item i_item,
    input  logic               i_out_busy,
    output logic               o_advance,
    output logic               o_res_valid,
    output prmp_pkg::t_out_item o_res
);
    import prmp_pkg::*;

    localparam logic [WORD_W-1:0] CAP_VAL = WORD_W'(DESC_CAP);

    logic [POS_W-1:0]  r_pos,  n_pos;
    logic [END_W-1:0]  r_end,  n_end;
    logic [WORD_W-1:0] r_ws,   n_ws;
    logic [WORD_W-1:0] r_hold, n_hold;
    logic [WORD_W-1:0] r_max,  n_max;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;

    logic              active;
    logic              in_desc;
    logic [POS_W-1:0]  rel_pos;
    logic [OFF_W-1:0]  off;
    logic              fits;
    logic              below_cap;
    logic [WORD_W-1:0] max_a;
    logic              ok;

    // a last byte needs a free result slot, other bytes always move
    assign o_advance = i_valid && (!i_item.last_byte || !i_out_busy);

    assign active    = (r_pos != POS_MAX);
    assign in_desc   = (r_pos >= HDR_BYTES);
    assign rel_pos   = r_pos - HDR_BYTES;
    assign off       = rel_pos[OFF_W-1:0];
    assign fits      = ({{(END_W-POS_W){1'b0}}, r_pos} + END_W'(1)) <= r_end;
    assign below_cap = {{(WORD_W-CNT_W){1'b0}}, r_cnt} < CAP_VAL;
    assign max_a     = (r_hold > r_max) ? r_hold : r_max;

    always_comb begin
        n_pos  = r_pos;
        n_end  = r_end;
        n_ws   = r_ws;
        n_hold = r_hold;
        n_max  = r_max;
        n_cnt  = r_cnt;
        if (active) begin
            n_ws  = {r_ws[WORD_W-9:0], i_item.data_byte};
            n_pos = r_pos + POS_W'(1);
            if (r_pos == LEN_LAST) begin
                n_end = {1'b0, n_ws} + LEN_ADD;
            end else if (in_desc) begin
                if (off == OFF_START) begin
                    n_hold = n_ws;
                end else if (off == OFF_END && fits && below_cap) begin
                    n_max = (n_ws > max_a) ? n_ws : max_a;
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
        end
    end

    assign ok = (r_pos >= HDR_LAST) && (n_end >= END_MIN);

    assign o_res_valid            = o_advance && i_item.last_byte;
    assign o_res.header_ok        = ok;
    assign o_res.peak_perf        = ok ? n_max : '0;
    assign o_res.descriptor_count = ok ? n_cnt : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_res_valid) begin
            r_pos  <= '0;
            r_end  <= '0;
            r_ws   <= '0;
            r_hold <= '0;
            r_max  <= '0;
            r_cnt  <= '0;
        end else if (o_advance) begin
            r_pos  <= n_pos;
            r_end  <= n_end;
            r_ws   <= n_ws;
            r_hold <= n_hold;
            r_max  <= n_max;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// File: hdl/prmp_out_reg.sv
// result register: holds the reply summary until the receiver takes it
module prmp_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_res_valid,
    input  prmp_pkg::t_out_item i_res,
    input  logic                i_stall,
    output logic                o_busy,
    output logic                o_valid,
    output prmp_pkg::t_out_item o_item
);
    import prmp_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    assign o_busy = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res_valid) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_item <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: hdl/performance_reply_max_parser_core.sv
// Parser for a GET PERFORMANCE type 0 reply streamed one byte per request.
// Input channel: i_in_valid / o_in_stall carry one byte and a last flag.
// Output channel: o_out_valid / i_out_stall carry one summary per reply:
// header_ok, the largest start or end performance and the descriptor count.
// An accepted byte sits in the input register and is folded into the
// parse state from there; the summary of a last byte is captured in the
// result register as that byte is consumed. Throughput is one byte per
// cycle when no summary is stalled: the per-byte work is a shift, one
// length compare and a three-way max, all combinational after the input
// register. Non-last bytes keep flowing while a summary waits in the
// result register; a last byte waits in the input register only while a
// previous summary is still stalled, and then o_in_stall rises.
// After the last byte the parse state returns to its reset values, ready
// for the next reply. Synchronous active-low reset empties both registers
// and clears the parse state; no clearing pass is needed.
module performance_reply_max_parser_core #(
    parameter int unsigned DESC_CAP = prmp_pkg::DESC_CAP_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  prmp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output prmp_pkg::t_out_item o_out_item
);
    import prmp_pkg::*;

    logic      in_valid;
    t_in_item  in_item;
    logic      advance;
    logic      out_busy;
    logic      res_valid;
    t_out_item res;

    prmp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_item    (i_in_item),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_item    (in_item)
    );

    prmp_engine #(
        .DESC_CAP (DESC_CAP)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .i_item      (in_item),
        .i_out_busy  (out_busy),
        .o_advance   (advance),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    prmp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_stall     (i_out_stall),
        .o_busy      (out_busy),
        .o_valid     (o_out_valid),
        .o_item      (o_out_item)
    );

endmodule

// File: hdl/prmp_checker.sv
// port-level checks for the parser, bound to the top level
module prmp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input prmp_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input prmp_pkg::t_out_item o_out_item
);
    import prmp_pkg::*;

    // a held result must not change under stall
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // a bad header reports nothing else
    a_bad_hdr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.header_ok |->
            o_out_item.peak_perf == '0 && o_out_item.descriptor_count == '0)
        else $error("bad header with nonzero max or count");

    // a nonzero max needs at least one counted descriptor
    a_max_needs_desc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.peak_perf != '0 |->
            o_out_item.descriptor_count != '0)
        else $error("nonzero max without descriptors");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind performance_reply_max_parser_core prmp_checker u_prmp_checker (.*);
